/* hdl/wsqg_pkg.sv */
// ----------------------------------------------------------------------------
// wsqg_pkg
// Shared types and constants of the waveform SNR quality grader.
// ----------------------------------------------------------------------------
package wsqg_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int COUNT_BITS_DEF    = 16;
	localparam int RMS_FRAC_BITS_DEF = 8;

	localparam int CFG_W     = 16;
	localparam int SUM_W     = 48;
	localparam int LOG_W     = 21;
	localparam int PROD_W    = 52;
	localparam int SNR_W     = 16;
	localparam int GRADE_W   = 2;

	localparam logic [CFG_W-1:0] COUNT_RESET  = 16'd1024;
	localparam logic [19:0]      START_RECIP  = 20'd838861;
	localparam logic signed [26:0] SNR_SCALE  = 27'sd50504453;
	localparam logic signed [SNR_W-1:0] SNR_MIN  = -16'sd32768;
	localparam logic signed [SNR_W-1:0] SNR_MAX  = 16'sd32767;
	localparam logic signed [SNR_W-1:0] GOOD_LIMIT = 16'sd2560;
	localparam logic signed [SNR_W-1:0] FAIR_LIMIT = 16'sd1280;

	localparam logic [GRADE_W-1:0] GRADE_GOOD = 2'd0;
	localparam logic [GRADE_W-1:0] GRADE_FAIR = 2'd1;
	localparam logic [GRADE_W-1:0] GRADE_POOR = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIV_STEP,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_LOGR_LOAD,
		OP_LOGP_LOAD,
		OP_LOG_NORM,
		OP_LOG_ROUND,
		OP_MUL,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic rec_last;
		logic norm_done;
	} dp_status_t;

	// The noise tail starts at floor(count*9/10), done by a reciprocal multiply.
	function automatic logic [CFG_W-1:0] tail_start(input logic [CFG_W-1:0] c);
		logic [39:0] p;
		p = 40'(20'(c) * 20'd9) * 40'(START_RECIP);
		return p[38:23];
	endfunction

endpackage

/* hdl/wsqg_ctrl.sv */
// ----------------------------------------------------------------------------
// wsqg_ctrl
// Sequencer for the end-of-record division, root, logarithms and scaling.
// ----------------------------------------------------------------------------
module wsqg_ctrl #(
	parameter int RMS_FRAC_BITS = wsqg_pkg::RMS_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  wsqg_pkg::dp_status_t status,
	output wsqg_pkg::dp_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);
	import wsqg_pkg::*;

	localparam int DIV_STEPS = SUM_W + 2 * RMS_FRAC_BITS;
	localparam int IW = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_SQRT_LD, S_SQRT, S_LOGR_LD, S_NORM_R, S_RND_R,
		S_LOGP_LD, S_NORM_P, S_RND_P, S_MUL, S_FIN
	} state_t;

	state_t        st_q;
	logic [IW-1:0] iter_q;
	logic          busy_q;
	logic          done_q;

	always_comb begin
		cmd.accept = start && (st_q == S_IDLE);
		case (st_q)
			S_DIV:     cmd.op = OP_DIV_STEP;
			S_SQRT_LD: cmd.op = OP_SQRT_INIT;
			S_SQRT:    cmd.op = OP_SQRT_STEP;
			S_LOGR_LD: cmd.op = OP_LOGR_LOAD;
			S_LOGP_LD: cmd.op = OP_LOGP_LOAD;
			S_NORM_R,
			S_NORM_P:  cmd.op = status.norm_done ? OP_NONE : OP_LOG_NORM;
			S_RND_R,
			S_RND_P:   cmd.op = OP_LOG_ROUND;
			S_MUL:     cmd.op = OP_MUL;
			S_FIN:     cmd.op = OP_FINISH;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			iter_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == S_FIN);
			case (st_q)
				S_IDLE: begin
					if (cmd.accept && status.rec_last) begin
						st_q   <= S_DIV;
						iter_q <= IW'(DIV_STEPS - 1);
						busy_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (iter_q == '0) st_q <= S_SQRT_LD;
					else iter_q <= iter_q - 1'b1;
				end
				S_SQRT_LD: begin
					st_q   <= S_SQRT;
					iter_q <= IW'(31);
				end
				S_SQRT: begin
					if (iter_q == '0) st_q <= S_LOGR_LD;
					else iter_q <= iter_q - 1'b1;
				end
				S_LOGR_LD: st_q <= S_NORM_R;
				S_NORM_R: begin
					if (status.norm_done) begin
						st_q   <= S_RND_R;
						iter_q <= IW'(15);
					end
				end
				S_RND_R: begin
					if (iter_q == '0) st_q <= S_LOGP_LD;
					else iter_q <= iter_q - 1'b1;
				end
				S_LOGP_LD: st_q <= S_NORM_P;
				S_NORM_P: begin
					if (status.norm_done) begin
						st_q   <= S_RND_P;
						iter_q <= IW'(15);
					end
				end
				S_RND_P: begin
					if (iter_q == '0) st_q <= S_MUL;
					else iter_q <= iter_q - 1'b1;
				end
				S_MUL: st_q <= S_FIN;
				S_FIN: begin
					st_q   <= S_IDLE;
					busy_q <= 1'b0;
				end
				default: begin
					st_q   <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

/* hdl/wsqg_dp.sv */
// ----------------------------------------------------------------------------
// wsqg_dp
// Record accumulators, serial divider, serial square root, shared log unit
// and the final scaling and grading.
// ----------------------------------------------------------------------------
module wsqg_dp #(
	parameter int SAMPLE_BITS   = wsqg_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS    = wsqg_pkg::COUNT_BITS_DEF,
	parameter int RMS_FRAC_BITS = wsqg_pkg::RMS_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wsqg_pkg::dp_cmd_t                    cmd,
	output wsqg_pkg::dp_status_t                 status,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 cfg_we,
	input  logic [wsqg_pkg::CFG_W-1:0]           cfg_wdata,
	output logic [SAMPLE_BITS-1:0]               peak_to_peak,
	output logic signed [wsqg_pkg::SNR_W-1:0]    snr_db,
	output logic [wsqg_pkg::GRADE_W-1:0]         grade,
	output logic                                 is_good
);
	import wsqg_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int CB = COUNT_BITS;
	localparam int FB2 = 2 * RMS_FRAC_BITS;
	localparam int DW = SUM_W + FB2;

	logic [CFG_W-1:0] count_q, start_q, n_q;
	logic [CB-1:0]    idx_q;
	logic signed [SB-1:0] max_q, min_q;
	logic [SUM_W-1:0] sum_q;
	logic [SB-1:0]    pp_q;
	logic [15:0]      rem_q;
	logic [DW-1:0]    quo_q;
	logic [63:0]      v_q;
	logic [33:0]      srem_q;
	logic [31:0]      root_q;
	logic [31:0]      m_q;
	logic [4:0]       k_q;
	logic [15:0]      frac_q;
	logic [LOG_W-1:0] lrms_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SB-1:0]    pp_out_q;
	logic signed [SNR_W-1:0] snr_q;
	logic [GRADE_W-1:0] grade_q;

	logic [CFG_W-1:0] cfg_eff;
	logic signed [SB-1:0] new_max, new_min;
	logic signed [SB:0] diff, se, abs_v;
	logic [SB-1:0]    abs_u;
	logic [2*SB-1:0]  sq;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_next;
	logic [CB:0]      taken;
	logic             in_tail;
	logic [16:0]      r2;
	logic             div_ge;
	logic [95:0]      q_ext;
	logic [63:0]      v_sat;
	logic [33:0]      sr, trial;
	logic             sq_ge;
	logic [63:0]      msq;
	logic [32:0]      mt;
	logic signed [23:0] d;
	logic             neg;
	logic [PROD_W-1:0] mag;
	logic [PROD_W-1:0] rnd;
	logic signed [SNR_W-1:0] snr_v;

	always_comb begin
		cfg_eff = (cfg_wdata == '0) ? CFG_W'(1) : cfg_wdata;
		new_max = (sample > max_q) ? sample : max_q;
		new_min = (sample < min_q) ? sample : min_q;
		diff    = {new_max[SB-1], new_max} - {new_min[SB-1], new_min};
		se      = {sample[SB-1], sample};
		abs_v   = se[SB] ? -se : se;
		abs_u   = abs_v[SB-1:0];
		sq      = (2*SB)'(abs_u) * (2*SB)'(abs_u);
		sum_add = (SUM_W+1)'(sum_q) + (SUM_W+1)'(sq);
		in_tail = 21'(idx_q) >= 21'(start_q);
		sum_next = !in_tail ? sum_q : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
		taken   = (CB+1)'(idx_q) + 1'b1;
		status.rec_last  = 21'(taken) >= 21'(count_q);
		status.norm_done = m_q[31];

		r2     = {rem_q, quo_q[DW-1]};
		div_ge = r2 >= 17'(n_q);
		q_ext  = 96'(quo_q);
		v_sat  = (q_ext[95:64] != '0) ? '1 : q_ext[63:0];

		sr    = {srem_q[31:0], v_q[63:62]};
		trial = {root_q, 2'b01};
		sq_ge = sr >= trial;

		msq = 64'(m_q) * 64'(m_q);
		mt  = msq[63:31];

		d = $signed({3'b000, k_q, frac_q}) + $signed(24'(RMS_FRAC_BITS << 16))
			- $signed({3'b000, lrms_q});

		neg = prod_q[PROD_W-1];
		mag = neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		rnd = (mag + (PROD_W'(1) << 31)) >> 32;
		if (pp_q == '0) begin
			snr_v = SNR_MIN;
		end else if (!neg) begin
			snr_v = (rnd > PROD_W'(32767)) ? SNR_MAX : $signed(SNR_W'(rnd));
		end else begin
			snr_v = (rnd >= PROD_W'(32768)) ? SNR_MIN : -$signed(SNR_W'(rnd));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			start_q <= tail_start(COUNT_RESET);
			n_q     <= COUNT_RESET - tail_start(COUNT_RESET);
			idx_q   <= '0;
			max_q   <= {1'b1, {(SB-1){1'b0}}};
			min_q   <= {1'b0, {(SB-1){1'b1}}};
			sum_q   <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_eff;
				start_q <= tail_start(cfg_eff);
				n_q     <= cfg_eff - tail_start(cfg_eff);
			end
			if (cmd.accept) begin
				if (status.rec_last) begin
					idx_q <= '0;
					max_q <= {1'b1, {(SB-1){1'b0}}};
					min_q <= {1'b0, {(SB-1){1'b1}}};
					sum_q <= '0;
				end else begin
					idx_q <= taken[CB-1:0];
					max_q <= new_max;
					min_q <= new_min;
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && status.rec_last) begin
			pp_q  <= diff[SB-1:0];
			quo_q <= {sum_next, {FB2{1'b0}}};
			rem_q <= '0;
		end
		case (cmd.op)
			OP_DIV_STEP: begin
				rem_q <= div_ge ? 16'(r2 - 17'(n_q)) : r2[15:0];
				quo_q <= {quo_q[DW-2:0], div_ge};
			end
			OP_SQRT_INIT: begin
				v_q    <= v_sat;
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				srem_q <= sq_ge ? sr - trial : sr;
				root_q <= {root_q[30:0], sq_ge};
				v_q    <= v_q << 2;
			end
			OP_LOGR_LOAD: begin
				m_q    <= (root_q == '0) ? 32'd1 : root_q;
				k_q    <= 5'd31;
				frac_q <= '0;
			end
			OP_LOGP_LOAD: begin
				lrms_q <= {k_q, frac_q};
				m_q    <= (pp_q == '0) ? 32'd1 : 32'(pp_q);
				k_q    <= 5'd31;
				frac_q <= '0;
			end
			OP_LOG_NORM: begin
				m_q <= m_q << 1;
				k_q <= k_q - 1'b1;
			end
			OP_LOG_ROUND: begin
				frac_q <= {frac_q[14:0], mt[32]};
				m_q    <= mt[32] ? mt[32:1] : mt[31:0];
			end
			OP_MUL: begin
				prod_q <= d * SNR_SCALE;
			end
			OP_FINISH: begin
				pp_out_q <= pp_q;
				snr_q    <= snr_v;
				if (snr_v > GOOD_LIMIT) grade_q <= GRADE_GOOD;
				else if (snr_v > FAIR_LIMIT) grade_q <= GRADE_FAIR;
				else grade_q <= GRADE_POOR;
			end
			default: begin
			end
		endcase
	end

	assign peak_to_peak = pp_out_q;
	assign snr_db       = snr_q;
	assign grade        = grade_q;
	assign is_good      = (grade_q != GRADE_POOR);

endmodule

/* hdl/waveform_snr_quality_grader_unit.sv */
// ----------------------------------------------------------------------------
// waveform_snr_quality_grader_unit
// Peak-to-peak SNR estimator and quality grader over one record of samples.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  input    | start && !busy       | sample
//  config   | cfg_we               | cfg_wdata (sample_count)
//  result   | done (one cycle)     | peak_to_peak, snr_db, grade, is_good
//
// While busy is low one sample word is taken in each cycle that start is high.
// The last sample of a record raises busy while the serial divider, the serial
// root and the shared log unit run; how long depends on RMS_FRAC_BITS and on
// kr and kp, the msb positions of the noise RMS and of the peak.
// The result word is shown with done in the cycle busy falls.
// Reset is asynchronous and clears the record and the count to 1024.
// The receiver cannot stall, so there is no back pressure on results.
module waveform_snr_quality_grader_unit #(
	parameter int SAMPLE_BITS   = wsqg_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS    = wsqg_pkg::COUNT_BITS_DEF,
	parameter int RMS_FRAC_BITS = wsqg_pkg::RMS_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              cfg_we,
	input  logic [wsqg_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                              done,
	output logic [SAMPLE_BITS-1:0]            peak_to_peak,
	output logic signed [wsqg_pkg::SNR_W-1:0] snr_db,
	output logic [wsqg_pkg::GRADE_W-1:0]      grade,
	output logic                              is_good
);
	import wsqg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	wsqg_ctrl #(.RMS_FRAC_BITS(RMS_FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.cmd(cmd), .busy(busy), .done(done)
	);

	wsqg_dp #(
		.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS),
		.RMS_FRAC_BITS(RMS_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.sample(sample), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.peak_to_peak(peak_to_peak), .snr_db(snr_db), .grade(grade),
		.is_good(is_good)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result repeated");

	a_zero_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(done && peak_to_peak == '0) |-> (snr_db == SNR_MIN && grade == GRADE_POOR))
		else $error("zero peak not saturated");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without a sample");

endmodule
